// ===== sv/gpop_pkg.sv =====
`timescale 1ns / 1ps

package gpop_pkg;

	// configuration register indexes
	localparam logic [2:0] CFG_SPOT   = 3'd0;
	localparam logic [2:0] CFG_STRIKE = 3'd1;
	localparam logic [2:0] CFG_DRIFT  = 3'd2;
	localparam logic [2:0] CFG_SCALE  = 3'd3;
	localparam logic [2:0] CFG_STEPS  = 3'd4;
	localparam logic [2:0] CFG_PATHS  = 3'd5;

	// reset values
	localparam logic [31:0] SPOT_RST   = 32'h0001_0000;
	localparam logic [31:0] STRIKE_RST = 32'h0001_0000;

	// Taylor series length and exponent clamp (2.0 in Q.28)
	localparam logic [4:0]  NUM_TERMS = 5'd20;
	localparam logic [29:0] EXP_MAX   = 30'h2000_0000;

	// 1.0 in Q1.62
	localparam logic [63:0] Q62_ONE = 64'h4000_0000_0000_0000;

	// multiplier operand select
	typedef enum logic [1:0] {
		MS_TERM  = 2'd0,
		MS_SUM   = 2'd1,
		MS_SQ    = 2'd2,
		MS_PRICE = 2'd3
	} mul_sel_t;

	// controller to datapath commands
	typedef struct packed {
		logic       load;
		logic       mul_en;
		logic       mul_first;
		logic [1:0] pp;
		mul_sel_t   mul_sel;
		logic       div_en;
		logic       div_first;
		logic       div_last;
		logic [4:0] k;
		logic       sq_store;
		logic       exp_store;
		logic       upd;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic end_path;
		logic out_busy;
	} sts_t;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_TMUL = 9'b000000010,
		S_DIV  = 9'b000000100,
		S_SQ1  = 9'b000001000,
		S_SQS  = 9'b000010000,
		S_SQ2  = 9'b000100000,
		S_EXS  = 9'b001000000,
		S_PMUL = 9'b010000000,
		S_UPD  = 9'b100000000
	} state_t;

endpackage

// ===== sv/gpop_ctrl.sv =====
`timescale 1ns / 1ps

module gpop_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  gpop_pkg::sts_t  sts,
	output gpop_pkg::cmd_t  cmd
);
	import gpop_pkg::*;

	state_t     state_q;
	logic [3:0] cnt_q;
	logic [4:0] k_q;

	assign in_stall = (state_q != S_IDLE);

	// command decode
	always_comb begin
		cmd           = '0;
		cmd.mul_sel   = MS_TERM;
		cmd.k         = k_q;
		cmd.pp        = cnt_q[1:0];
		cmd.mul_first = (cnt_q == 4'd0);
		cmd.div_first = (cnt_q == 4'd0);
		cmd.div_last  = (cnt_q == 4'd15);
		unique case (state_q)
			S_IDLE: cmd.load = in_valid;
			S_TMUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_TERM;
			end
			S_DIV:  cmd.div_en = 1'b1;
			S_SQ1: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_SUM;
			end
			S_SQS:  cmd.sq_store = 1'b1;
			S_SQ2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_SQ;
			end
			S_EXS:  cmd.exp_store = 1'b1;
			S_PMUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_PRICE;
			end
			S_UPD:  cmd.upd = !(sts.end_path && sts.out_busy);
			default: cmd = '0;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			k_q     <= 5'd1;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					k_q   <= 5'd1;
					if (in_valid) state_q <= S_TMUL;
				end
				S_TMUL: begin
					if (cnt_q == 4'd3) begin
						cnt_q   <= '0;
						state_q <= S_DIV;
					end else cnt_q <= cnt_q + 4'd1;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						if (k_q == NUM_TERMS) state_q <= S_SQ1;
						else begin
							k_q     <= k_q + 5'd1;
							state_q <= S_TMUL;
						end
					end
				end
				S_SQ1: begin
					if (cnt_q == 4'd3) begin
						cnt_q   <= '0;
						state_q <= S_SQS;
					end else cnt_q <= cnt_q + 4'd1;
				end
				S_SQS: state_q <= S_SQ2;
				S_SQ2: begin
					if (cnt_q == 4'd3) begin
						cnt_q   <= '0;
						state_q <= S_EXS;
					end else cnt_q <= cnt_q + 4'd1;
				end
				S_EXS: state_q <= S_PMUL;
				// one partial product: both operands fit the low half
				S_PMUL: state_q <= S_UPD;
				S_UPD: begin
					if (!(sts.end_path && sts.out_busy)) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== sv/gpop_dp.sv =====
`timescale 1ns / 1ps

module gpop_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [2:0]             cfg_index,
	input  logic [31:0]            cfg_data,
	input  logic signed [15:0]     normal_sample,
	input  gpop_pkg::cmd_t         cmd,
	output gpop_pkg::sts_t         sts,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [31:0]            terminal_price,
	output logic [63:0]            call_payoff_sum,
	output logic [63:0]            put_payoff_sum,
	output logic                   last_path
);
	import gpop_pkg::*;

	// configuration
	logic [31:0] spot_q, strike_q, drift_q;
	logic [15:0] scale_q, steps_q;
	logic [23:0] paths_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spot_q   <= SPOT_RST;
			strike_q <= STRIKE_RST;
			drift_q  <= '0;
			scale_q  <= '0;
			steps_q  <= 16'd1;
			paths_q  <= 24'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SPOT:   spot_q   <= cfg_data;
				CFG_STRIKE: strike_q <= cfg_data;
				CFG_DRIFT:  drift_q  <= cfg_data;
				CFG_SCALE:  scale_q  <= cfg_data[15:0];
				CFG_STEPS:  steps_q  <= cfg_data[15:0];
				CFG_PATHS:  paths_q  <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// exponent: drift + 2 * scale * sample, clamped to +-2.0
	logic signed [32:0] dprod;
	logic signed [34:0] expo;
	logic               neg_d;
	logic [29:0]        mag_d;

	always_comb begin
		dprod = normal_sample * $signed({1'b0, scale_q});
		expo  = $signed({{3{drift_q[31]}}, drift_q}) + $signed({dprod[32], dprod, 1'b0});
		neg_d = expo[34];
		if (expo > $signed({5'd0, EXP_MAX})) mag_d = EXP_MAX;
		else if (expo < -$signed({5'd0, EXP_MAX})) mag_d = EXP_MAX;
		else if (neg_d) mag_d = 30'(-expo);
		else mag_d = expo[29:0];
	end

	// series state
	logic         neg_q;
	logic [29:0]  mag_q;
	logic [63:0]  term_q, sum_q;
	logic [31:0]  exp_q;
	logic [127:0] acc_q;
	logic [31:0]  price_q;

	// shared 32x32 multiplier, one partial product a cycle
	logic [63:0]  op_a, op_b, pprod;
	logic [31:0]  half_a, half_b;
	logic [127:0] pp_sh;

	always_comb begin
		unique case (cmd.mul_sel)
			MS_TERM: begin
				op_a = term_q;
				op_b = {34'd0, mag_q};
			end
			MS_SUM: begin
				op_a = sum_q;
				op_b = sum_q;
			end
			MS_SQ: begin
				op_a = term_q;
				op_b = term_q;
			end
			MS_PRICE: begin
				op_a = {32'd0, price_q};
				op_b = {32'd0, exp_q};
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
		half_a = cmd.pp[0] ? op_a[63:32] : op_a[31:0];
		half_b = cmd.pp[1] ? op_b[63:32] : op_b[31:0];
		pprod  = {32'd0, half_a} * {32'd0, half_b};
		unique case (cmd.pp)
			2'd0:    pp_sh = {64'd0, pprod};
			2'd3:    pp_sh = {pprod, 64'd0};
			default: pp_sh = {32'd0, pprod, 32'd0};
		endcase
	end

	// divide by k, four quotient bits a cycle
	logic [63:0] div_q, div_src;
	logic [4:0]  rem_q, rem_n;
	logic [5:0]  r6;

	always_comb begin
		div_src = cmd.div_first ? acc_q[93:30] : div_q;
		rem_n   = cmd.div_first ? 5'd0 : rem_q;
		r6      = '0;
		for (int i = 0; i < 4; i++) begin
			r6 = {rem_n, div_src[63]};
			if (r6 >= {1'b0, cmd.k}) begin
				rem_n   = 5'(r6 - {1'b0, cmd.k});
				div_src = {div_src[62:0], 1'b1};
			end else begin
				rem_n   = r6[4:0];
				div_src = {div_src[62:0], 1'b0};
			end
		end
	end

	// squared value, rounded exp
	logic [63:0] exp_rnd;
	assign exp_rnd = acc_q[127:64] + 64'h4000_0000;

	// path bookkeeping
	logic [15:0] step_q, step_n, steps_eff;
	logic [23:0] path_q, paths_eff;
	logic [63:0] call_q, put_q;
	logic [63:0] prod_rnd;
	logic [31:0] p_new, pay_diff;
	logic [64:0] call_add, put_add;
	logic [63:0] call_n, put_n;
	logic        end_path, last_n;

	always_comb begin
		prod_rnd  = acc_q[63:0] + 64'h1000_0000;
		p_new     = (prod_rnd[63:61] != 3'd0) ? 32'hFFFF_FFFF : prod_rnd[60:29];
		steps_eff = (steps_q == 16'd0) ? 16'd1 : steps_q;
		paths_eff = (paths_q == 24'd0) ? 24'd1 : paths_q;
		step_n    = step_q + 16'd1;
		end_path  = (step_n == 16'd0) || (step_n >= steps_eff);
		last_n    = ({1'b0, path_q} + 25'd1) >= {1'b0, paths_eff};
		call_n    = call_q;
		put_n     = put_q;
		pay_diff  = '0;
		if (p_new > strike_q) begin
			pay_diff = p_new - strike_q;
			call_add = {1'b0, call_q} + {33'd0, pay_diff};
			put_add  = '0;
			call_n   = call_add[64] ? 64'hFFFF_FFFF_FFFF_FFFF : call_add[63:0];
		end else begin
			pay_diff = strike_q - p_new;
			call_add = '0;
			put_add  = {1'b0, put_q} + {33'd0, pay_diff};
			if (p_new < strike_q)
				put_n = put_add[64] ? 64'hFFFF_FFFF_FFFF_FFFF : put_add[63:0];
		end
	end

	assign sts.end_path = end_path;
	assign sts.out_busy = out_valid && out_stall;

	// arithmetic registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q  <= neg_d;
			mag_q  <= mag_d;
			term_q <= Q62_ONE;
			sum_q  <= Q62_ONE;
		end
		if (cmd.mul_en)
			acc_q <= (cmd.mul_first ? 128'd0 : acc_q) + pp_sh;
		if (cmd.div_en) begin
			div_q <= div_src;
			rem_q <= rem_n;
			if (cmd.div_last) begin
				term_q <= div_src;
				sum_q  <= (neg_q && cmd.k[0]) ? sum_q - div_src : sum_q + div_src;
			end
		end
		if (cmd.sq_store)
			term_q <= acc_q[125:62];
		if (cmd.exp_store)
			exp_q <= exp_rnd[62:31];
	end

	// path state and result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			price_q   <= SPOT_RST;
			step_q    <= '0;
			path_q    <= '0;
			call_q    <= '0;
			put_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (cmd.upd) begin
				if (!end_path) begin
					price_q <= p_new;
					step_q  <= step_n;
				end else begin
					price_q   <= spot_q;
					step_q    <= '0;
					out_valid <= 1'b1;
					if (last_n) begin
						path_q <= '0;
						call_q <= '0;
						put_q  <= '0;
					end else begin
						path_q <= path_q + 24'd1;
						call_q <= call_n;
						put_q  <= put_n;
					end
				end
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.upd && end_path) begin
			terminal_price  <= p_new;
			call_payoff_sum <= call_n;
			put_payoff_sum  <= put_n;
			last_path       <= last_n;
		end
	end

endmodule

// ===== sv/gbm_path_option_payoff.sv =====
`timescale 1ns / 1ps

// GBM path stepper with European call/put payoff sums.
// Input channel (in_valid/in_stall/normal_sample): one normal draw per beat,
// each beat advances the current path by one price step.
// Output channel (out_valid/out_stall/...): one beat at the end of every path
// with the terminal price, running call/put sums and the last-path flag.
// Configuration: cfg_we/cfg_index/cfg_data, written while the block is idle.
// The exp evaluation runs 20 series terms, each a multiply on the shared
// 32x32 multiplier and a divide by the term index, then two squarings and
// the price multiply.
// One input beat is processed at a time; the result register holds a
// finished beat so the next input can be taken while it waits.
// If the receiver stalls, the beat holds and a following path end waits
// in its update cycle until the register frees.
// Reset: registers return to their defaults, price to 1.0, counters and
// sums to zero, no beat pending.
module gbm_path_option_payoff (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] normal_sample,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        terminal_price,
	output logic [63:0]        call_payoff_sum,
	output logic [63:0]        put_payoff_sum,
	output logic               last_path
);
	import gpop_pkg::*;

	cmd_t cmd;
	sts_t sts;

	gpop_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	gpop_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.normal_sample   (normal_sample),
		.cmd             (cmd),
		.sts             (sts),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.terminal_price  (terminal_price),
		.call_payoff_sum (call_payoff_sum),
		.put_payoff_sum  (put_payoff_sum),
		.last_path       (last_path)
	);

endmodule
